/* rtl/core/obsl_pkg.sv */
// Shared types, sizes and helpers for the opening book sorted lookup block.
`default_nettype none

package obsl_pkg;

  // Table sizes
  localparam int MAX_ENTRIES   = 1024;
  localparam int MOVES_PER_KEY = 32;
  localparam int MAX_MOVES     = 4096;

  localparam int ENTRY_IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int MOVE_IW  = (MAX_MOVES > 1) ? $clog2(MAX_MOVES) : 1;
  localparam int MFILL_W  = $clog2(MAX_MOVES + 1);
  localparam int MCNT_W   = $clog2(MOVES_PER_KEY + 1);

  // Field widths
  localparam int KEY_W   = 64;
  localparam int WORD_W  = 16;
  localparam int SQ_W    = 3;
  localparam int DMOVE_W = 4 * SQ_W;
  localparam int MNUM_W  = 5;

  // Commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_FIND  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Promotion codes that are kept, and the top row index
  localparam logic [SQ_W-1:0] PROMO_NONE  = 3'd0;
  localparam logic [SQ_W-1:0] PROMO_QUEEN = 3'd4;
  localparam logic [SQ_W-1:0] ROW_TOP     = 3'd7;

  typedef struct packed {
    logic [1:0]        command;
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] move_word;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [SQ_W-1:0]   from_file;
    logic [SQ_W-1:0]   from_rank;
    logic [SQ_W-1:0]   to_file;
    logic [SQ_W-1:0]   to_rank;
    logic [MNUM_W-1:0] move_number;
    logic              last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic find_init;
    logic probe;
    logic step;
    logic hit;
    logic move_rd;
    logic out_move;
    logic out_miss;
    logic out_pop;
    logic adv;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_empty;
    logic key_eq;
    logic out_last;
  } dp_stat_t;

  // Decoded move: from_file, from_rank, to_file, to_rank with ranks flipped
  function automatic logic [DMOVE_W-1:0] decode_move(input logic [WORD_W-1:0] w);
    logic [SQ_W-1:0] tf, tr, ff, fr;
    tf = w[2:0];
    tr = ROW_TOP - w[5:3];
    ff = w[8:6];
    fr = ROW_TOP - w[11:9];
    return {ff, fr, tf, tr};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/opening_book_sorted_lookup_top.sv */
// Top level of the opening book sorted lookup block.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall    obsl_pkg::in_item_t  (command, key, move_word)
//  out      output     out_valid / out_stall  obsl_pkg::out_item_t (found, squares, number, last)
//
//  Load and clear are done from the idle state; command 3 is dropped.
//  A find reads the key store, then compares, once per search probe, at most
//  log2(entries)+1 probes; a miss is seen as an empty range in the probe state. Each
//  result then goes through move read, result fill and emit, held in emit by a stall.
//  Items are taken one at a time: in_stall stays high until the last result has left.
//  Reset (rst_n low, synchronous) empties the table; stores hold no reset value.
//  A stall on out holds the result register and the controller in place.
`default_nettype none

module opening_book_sorted_lookup_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire obsl_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output obsl_pkg::out_item_t      out_item
);

  obsl_pkg::ctrl_cmd_t cmd;
  obsl_pkg::dp_stat_t  stat;
  logic                idle;

  assign in_stall = !idle;

  obsl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_item.command),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd),
    .idle       (idle)
  );

  obsl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

/* rtl/core/obsl_ctrl.sv */
// Controller state machine for the opening book sorted lookup block.
`default_nettype none

module obsl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_command,
  input  wire logic              out_stall,
  input  wire obsl_pkg::dp_stat_t stat,
  output obsl_pkg::ctrl_cmd_t    cmd,
  output logic                   idle
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PROBE = 6'b000010,
    S_CMP   = 6'b000100,
    S_MREAD = 6'b001000,
    S_FILL  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign idle   = (state_r == S_IDLE);
  assign accept = idle && in_valid;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == obsl_pkg::CMD_LOAD) begin
            cmd.load = 1'b1;
          end else if (in_command == obsl_pkg::CMD_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (in_command == obsl_pkg::CMD_FIND) begin
            cmd.find_init = 1'b1;
            state_nxt     = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (stat.range_empty) begin
          cmd.out_miss = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.key_eq) begin
          cmd.hit   = 1'b1;
          state_nxt = S_MREAD;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_MREAD: begin
        cmd.move_rd = 1'b1;
        state_nxt   = S_FILL;
      end
      S_FILL: begin
        cmd.out_move = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          cmd.out_pop = 1'b1;
          if (stat.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = S_MREAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A compare always follows a probe read
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> ($past(state_r) == S_PROBE))
    else $error("compare state entered without a probe");

  // After a pop, the controller moves on to idle or move read
  a_pop_leaves_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_pop |=> (state_r == S_IDLE || state_r == S_MREAD))
    else $error("emit state held after pop");

endmodule

`default_nettype wire

/* rtl/core/obsl_dp.sv */
// Datapath for the opening book sorted lookup block: stores, search and output register.
`default_nettype none

module obsl_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire obsl_pkg::in_item_t  in_item,
  input  wire obsl_pkg::ctrl_cmd_t cmd,
  output obsl_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  output obsl_pkg::out_item_t      out_item
);

  localparam int ENTRY_IW = obsl_pkg::ENTRY_IW;
  localparam int ECNT_W   = obsl_pkg::ECNT_W;
  localparam int MOVE_IW  = obsl_pkg::MOVE_IW;
  localparam int MFILL_W  = obsl_pkg::MFILL_W;
  localparam int MCNT_W   = obsl_pkg::MCNT_W;
  localparam int KEY_W    = obsl_pkg::KEY_W;
  localparam int DMOVE_W  = obsl_pkg::DMOVE_W;

  // Stores
  logic [KEY_W-1:0]   key_mem   [obsl_pkg::MAX_ENTRIES];
  logic [MOVE_IW-1:0] start_mem [obsl_pkg::MAX_ENTRIES];
  logic [MCNT_W-1:0]  count_mem [obsl_pkg::MAX_ENTRIES];
  logic [DMOVE_W-1:0] move_mem  [obsl_pkg::MAX_MOVES];

  // Table state
  logic [ECNT_W-1:0]  entry_count_r;
  logic [MFILL_W-1:0] move_fill_r;
  logic [KEY_W-1:0]   last_key_r;
  logic [MCNT_W-1:0]  last_cnt_r;

  // Search state
  logic [KEY_W-1:0]   key_r;
  logic [ECNT_W-1:0]  lo_r, hi_r, mid_r, mid;
  logic [KEY_W-1:0]   key_rd_r;
  logic [MOVE_IW-1:0] start_rd_r;
  logic [MCNT_W-1:0]  count_rd_r;

  // Stream state
  logic [MOVE_IW-1:0] base_r;
  logic [MCNT_W-1:0]  n_r, i_r;
  logic [DMOVE_W-1:0] move_rd_r;
  logic [MOVE_IW-1:0] move_addr;
  logic               last_move;

  logic                out_valid_r;
  obsl_pkg::out_item_t out_item_r;

  // Load decisions
  logic [2:0]         promo;
  logic               promo_ok, room_moves, same_key, do_append, do_new;
  logic [ENTRY_IW-1:0] new_idx, tail_idx;
  logic [MOVE_IW-1:0]  fill_idx;

  assign promo      = in_item.move_word[14:12];
  assign promo_ok   = (promo == obsl_pkg::PROMO_NONE) || (promo == obsl_pkg::PROMO_QUEEN);
  assign room_moves = move_fill_r < MFILL_W'(obsl_pkg::MAX_MOVES);
  assign same_key   = (entry_count_r != '0) && (last_key_r == in_item.key);
  assign do_append  = cmd.load && promo_ok && room_moves && same_key &&
                      (last_cnt_r < MCNT_W'(obsl_pkg::MOVES_PER_KEY));
  assign do_new     = cmd.load && promo_ok && room_moves && !same_key &&
                      (entry_count_r < ECNT_W'(obsl_pkg::MAX_ENTRIES));
  assign new_idx    = entry_count_r[ENTRY_IW-1:0];
  assign tail_idx   = ENTRY_IW'(entry_count_r - 1'b1);
  assign fill_idx   = move_fill_r[MOVE_IW-1:0];

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign move_addr = base_r + MOVE_IW'(i_r);
  assign last_move = ({1'b0, i_r} + 1'b1) == {1'b0, n_r};

  assign stat.range_empty = !(lo_r < hi_r);
  assign stat.key_eq      = (key_rd_r == key_r);
  assign stat.out_last    = out_item_r.last;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Key, start and count stores: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_new) begin
      key_mem[new_idx]   <= in_item.key;
      start_mem[new_idx] <= fill_idx;
    end
    if (do_new) begin
      count_mem[new_idx] <= MCNT_W'(1);
    end else if (do_append) begin
      count_mem[tail_idx] <= last_cnt_r + 1'b1;
    end
    if (cmd.probe) begin
      key_rd_r   <= key_mem[mid[ENTRY_IW-1:0]];
      start_rd_r <= start_mem[mid[ENTRY_IW-1:0]];
      count_rd_r <= count_mem[mid[ENTRY_IW-1:0]];
    end
  end

  // Move store
  always_ff @(posedge clk) begin
    if (do_new || do_append) begin
      move_mem[fill_idx] <= obsl_pkg::decode_move(in_item.move_word);
    end
    if (cmd.move_rd) begin
      move_rd_r <= move_mem[move_addr];
    end
  end

  // Table counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      move_fill_r   <= '0;
    end else if (cmd.clear) begin
      entry_count_r <= '0;
      move_fill_r   <= '0;
    end else begin
      if (do_new) begin
        entry_count_r <= entry_count_r + 1'b1;
      end
      if (do_new || do_append) begin
        move_fill_r <= move_fill_r + 1'b1;
      end
    end
  end

  // Tail entry shadow, avoids a read on load
  always_ff @(posedge clk) begin
    if (do_new) begin
      last_key_r <= in_item.key;
      last_cnt_r <= MCNT_W'(1);
    end else if (do_append) begin
      last_cnt_r <= last_cnt_r + 1'b1;
    end
  end

  // Binary search bounds
  always_ff @(posedge clk) begin
    if (cmd.find_init) begin
      key_r <= in_item.key;
      lo_r  <= '0;
      hi_r  <= entry_count_r;
    end else if (cmd.step) begin
      if (key_rd_r < key_r) begin
        lo_r <= mid_r + 1'b1;
      end else begin
        hi_r <= mid_r;
      end
    end
    if (cmd.probe) begin
      mid_r <= mid;
    end
  end

  // Move stream position
  always_ff @(posedge clk) begin
    if (cmd.hit) begin
      base_r <= start_rd_r;
      n_r    <= count_rd_r;
      i_r    <= '0;
    end else if (cmd.adv) begin
      i_r <= i_r + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_move || cmd.out_miss) begin
      out_valid_r <= 1'b1;
    end else if (cmd.out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_move) begin
      out_item_r.found       <= 1'b1;
      out_item_r.from_file   <= move_rd_r[11:9];
      out_item_r.from_rank   <= move_rd_r[8:6];
      out_item_r.to_file     <= move_rd_r[5:3];
      out_item_r.to_rank     <= move_rd_r[2:0];
      out_item_r.move_number <= obsl_pkg::MNUM_W'(i_r);
      out_item_r.last        <= last_move;
    end else if (cmd.out_miss) begin
      out_item_r.found       <= 1'b0;
      out_item_r.from_file   <= '0;
      out_item_r.from_rank   <= '0;
      out_item_r.to_file     <= '0;
      out_item_r.to_rank     <= '0;
      out_item_r.move_number <= '0;
      out_item_r.last        <= 1'b1;
    end
  end

  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= ECNT_W'(obsl_pkg::MAX_ENTRIES))
    else $error("entry count past table size");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    move_fill_r <= MFILL_W'(obsl_pkg::MAX_MOVES))
    else $error("move fill past store size");

  a_miss_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.found) |-> out_item_r.last)
    else $error("miss result not marked last");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load || cmd.clear) |-> !out_valid_r)
    else $error("table changed while a result is pending");

endmodule

`default_nettype wire

/* verif/obsl_checker.sv */
// Checker for the opening book lookup block: mirrors the table, predicts every find, compares.
`timescale 1ns / 1ps

module obsl_checker
  import obsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  logic [KEY_W-1:0]   book_key   [MAX_ENTRIES];
  int unsigned        book_first [MAX_ENTRIES];
  int unsigned        book_len   [MAX_ENTRIES];
  logic [DMOVE_W-1:0] book_move  [MAX_MOVES];
  int unsigned        entries_used = 0;
  int unsigned        moves_used = 0;
  out_item_t          moves_due[$];
  int                 errors = 0;

  function automatic string move_text(input out_item_t r);
    return $sformatf("found=%0d from=%0d/%0d to=%0d/%0d number=%0d last=%0d",
                     r.found, r.from_file, r.from_rank, r.to_file, r.to_rank,
                     r.move_number, r.last);
  endfunction

  task automatic store_record(input logic [KEY_W-1:0] key, input logic [WORD_W-1:0] w);
    logic [SQ_W-1:0] promo;
    int unsigned     e;
    promo = w[14:12];
    if (promo != PROMO_NONE && promo != PROMO_QUEEN) return;
    if (moves_used >= MAX_MOVES) return;
    if (entries_used != 0 && book_key[entries_used - 1] == key) begin
      // same key as the last entry: append, up to the per-key limit
      e = entries_used - 1;
      if (book_len[e] >= MOVES_PER_KEY) return;
      book_len[e] = book_len[e] + 1;
    end else begin
      if (entries_used >= MAX_ENTRIES) return;
      book_key[entries_used]   = key;
      book_first[entries_used] = moves_used;
      book_len[entries_used]   = 1;
      entries_used = entries_used + 1;
    end
    book_move[moves_used] = {w[8:6], ROW_TOP - w[11:9], w[2:0], ROW_TOP - w[5:3]};
    moves_used = moves_used + 1;
  endtask

  task automatic lookup_moves(input logic [KEY_W-1:0] key);
    int unsigned        lo, hi, mid;
    int                 hit;
    int unsigned        i;
    logic [DMOVE_W-1:0] m;
    out_item_t          r;
    lo  = 0;
    hi  = entries_used;
    hit = -1;
    while (lo < hi && hit < 0) begin
      mid = lo + (hi - lo) / 2;
      if (book_key[mid] == key) hit = int'(mid);
      else if (book_key[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    if (hit < 0) begin
      r      = '0;
      r.last = 1'b1;
      moves_due.push_back(r);
    end else begin
      for (i = 0; i < book_len[hit]; i++) begin
        m             = book_move[(book_first[hit] + i) % MAX_MOVES];
        r.found       = 1'b1;
        r.from_file   = m[11:9];
        r.from_rank   = m[8:6];
        r.to_file     = m[5:3];
        r.to_rank     = m[2:0];
        r.move_number = i[MNUM_W-1:0];
        r.last        = (i + 1 == book_len[hit]);
        moves_due.push_back(r);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      entries_used = 0;
      moves_used   = 0;
      moves_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        case (in_item.command)
          CMD_LOAD:  store_record(in_item.key, in_item.move_word);
          CMD_FIND:  lookup_moves(in_item.key);
          CMD_CLEAR: begin
            entries_used = 0;
            moves_used   = 0;
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (moves_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: %s", $time, move_text(out_item));
        end else begin
          want = moves_due.pop_front();
          if (out_item !== want) begin
            errors++;
            $display("%0t: result mismatch\n  expected %s\n  actual   %s", $time,
                     move_text(want), move_text(out_item));
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= moves_due.size();
  end

endmodule

/* verif/tb_top.sv */
// Testbench top for the opening book lookup block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import obsl_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         TAIL_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;

  logic [KEY_W-1:0] round_keys[$];

  opening_book_sorted_lookup_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  obsl_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Mostly kept promotion codes; bad_pct of the words keep a random code
  function automatic logic [WORD_W-1:0] book_word(input int bad_pct);
    logic [WORD_W-1:0] w;
    w = WORD_W'($urandom);
    if ($urandom_range(99) >= bad_pct) w[14:12] = $urandom_range(1) ? PROMO_QUEEN : PROMO_NONE;
    return w;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [WORD_W-1:0] word);
    in_item_t it;
    it.command   = cmd;
    it.key       = key;
    it.move_word = word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every predicted result has left the block
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Ascending keys spread over the whole key space, each with lo_moves to hi_moves moves
  task automatic load_round(input int n_keys, input int lo_moves, input int hi_moves,
                            input int bad_pct);
    logic [KEY_W-1:0] slot, k;
    int               i;
    slot = {KEY_W{1'b1}} / n_keys;
    round_keys.delete();
    for (i = 0; i < n_keys; i++) begin
      k = slot * i + (rand_key() % slot);
      round_keys.push_back(k);
      repeat ($urandom_range(lo_moves, hi_moves)) send_item(CMD_LOAD, k, book_word(bad_pct));
    end
  endtask

  task automatic find_round(input int n_finds);
    logic [KEY_W-1:0] k;
    int               pick;
    repeat (n_finds) begin
      pick = $urandom_range(99);
      if (round_keys.size() != 0 && pick < 60) begin
        k = round_keys[$urandom_range(round_keys.size() - 1)];
      end else if (round_keys.size() != 0 && pick < 75) begin
        k = round_keys[$urandom_range(round_keys.size() - 1)];
        k = $urandom_range(1) ? k + 1 : k - 1;
      end else begin
        k = rand_key();
      end
      send_item(CMD_FIND, k, WORD_W'($urandom));
    end
  endtask

  task automatic book_round();
    if ($urandom_range(99) < 80) send_item(CMD_CLEAR, rand_key(), WORD_W'($urandom));
    if ($urandom_range(9) == 0) send_item(CMD_UNUSED, rand_key(), WORD_W'($urandom));
    load_round($urandom_range(1, 12), 1, ($urandom_range(9) == 0) ? 34 : 4, 12);
    find_round($urandom_range(2, 8));
  endtask

  initial begin
    int               phase, phase_start;
    bit               held;
    held = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 45;
    send_item(CMD_FIND, 64'h0, 16'h0000);                   // empty table
    send_item(CMD_LOAD, 64'h0, 16'h0000);
    send_item(CMD_LOAD, 64'h0, 16'hCFFF);                   // queen, same key
    send_item(CMD_LOAD, 64'h0, 16'h1ABC);                   // dropped promotion
    send_item(CMD_LOAD, 64'h1234, 16'h2FFF);
    send_item(CMD_LOAD, 64'h1234, 16'hFFFF);
    send_item(CMD_LOAD, 64'h8000_0000_0000_0000, 16'h8E38);
    send_item(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h4A5C);
    send_item(CMD_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 16'h5FFF);
    send_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_item(CMD_FIND, 64'h0, 16'hFFFF);
    send_item(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
    send_item(CMD_FIND, 64'h8000_0000_0000_0000, 16'h0000);
    send_item(CMD_FIND, 64'h1234, 16'h0000);
    send_item(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFE, 16'h0000);
    send_item(CMD_FIND, 64'h1, 16'h0000);
    // keys out of order, and a key below every entry
    send_item(CMD_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    send_item(CMD_LOAD, 64'h50, 16'h0123);
    send_item(CMD_LOAD, 64'h20, 16'h4456);
    send_item(CMD_LOAD, 64'h90, 16'h0789);
    send_item(CMD_FIND, 64'h20, 16'h0000);
    send_item(CMD_FIND, 64'h50, 16'h0000);
    send_item(CMD_FIND, 64'h90, 16'h0000);
    send_item(CMD_FIND, 64'h10, 16'h0000);
    send_item(CMD_CLEAR, 64'h0, 16'h0000);
    send_item(CMD_FIND, 64'h50, 16'h0000);                  // cleared table
    drain();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 37 : 0;
      phase_start = items_sent;
      while (items_sent - phase_start < 100) begin
        book_round();
        if (!held && items_sent - phase_start > 40) begin
          // stall the results for a long stretch while finds keep coming
          held = 1'b1;
          hold_req <= hold_req + 1;
          find_round(6);
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/obsl_pkg.sv
rtl/core/obsl_ctrl.sv
rtl/core/obsl_dp.sv
rtl/core/opening_book_sorted_lookup_top.sv
verif/obsl_checker.sv
verif/tb_top.sv
